[sv/wdbr_pkg.sv]
// Shared types and constants for the LED duty-buffer refill block.
package wdbr_pkg;

    localparam int BITS_PER_PIXEL = 24;
    localparam int HALF_BITS      = BITS_PER_PIXEL / 2;
    localparam int COLOR_W        = 24;
    localparam int INDEX_W        = 10;
    localparam int SLOT_W         = 5;
    localparam int DUTY_W         = 8;
    localparam int COUNT_W        = 12;
    localparam int ACTIVE_W       = 11;
    localparam int FRAMES_W       = 8;
    localparam int CFG_INDEX_W    = 2;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = 2;
    localparam int QCNT_W         = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_PIXELS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_ONE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_ZERO     = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RESET_FRAMES  = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_EVENT = 1'b1;

    localparam logic [SLOT_W-1:0] SLOT_FIRST = 5'd0;
    localparam logic [SLOT_W-1:0] SLOT_MID   = 5'(HALF_BITS);
    localparam logic [SLOT_W-1:0] SLOT_HALF_END = 5'(HALF_BITS - 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST  = 5'(BITS_PER_PIXEL - 1);

    typedef struct packed {
        logic [ACTIVE_W-1:0] active_pixels;
        logic [DUTY_W-1:0]   duty_one;
        logic [DUTY_W-1:0]   duty_zero;
        logic [FRAMES_W-1:0] reset_frames;
    } cfg_t;

    typedef struct packed {
        logic               gap;
        logic [COLOR_W-1:0] color;
        logic [SLOT_W-1:0]  first_slot;
        logic [SLOT_W-1:0]  last_slot;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } cmd_req_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
        cmd_t              head;
    } queue_status_t;

endpackage

[sv/wdbr_front.sv]
// Front end: pixel store, pixel counter and classification of refill events.
module wdbr_front
    import wdbr_pkg::*;
#(
    parameter int PIXEL_DEPTH = 1024
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  logic                push,
    output logic                full,
    input  logic                kind,
    input  logic [INDEX_W-1:0]  pixel_index,
    input  logic [COLOR_W-1:0]  pixel_color,
    input  logic                half_flag,
    input  logic                done_flag,
    input  logic [QCNT_W-1:0]   queue_count,
    output cmd_req_t            cmd_req
);

    localparam int AW = (PIXEL_DEPTH > 1) ? $clog2(PIXEL_DEPTH) : 1;

    logic [COLOR_W-1:0] store_mem [PIXEL_DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;

    logic               clear_reg;
    logic [AW-1:0]      clear_addr_reg;
    logic [COUNT_W-1:0] counter_reg;
    logic [COUNT_W-1:0] counter_next;

    logic               s1_valid_reg;
    logic               s1_gap_reg;
    logic               s1_in_range_reg;
    logic [SLOT_W-1:0]  s1_first_reg;
    logic [SLOT_W-1:0]  s1_last_reg;

    logic               accept;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [COLOR_W-1:0] wr_data;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        idx_ext;
    logic [31:0]        ctr_ext;
    logic               in_active;
    logic               ctr_in_range;
    logic [COUNT_W-1:0] gap_diff;
    logic [FRAMES_W-1:0] gap_m1;
    logic               gap_end;
    logic               emit;
    logic               emit_gap;
    logic [SLOT_W-1:0]  emit_first;
    logic [SLOT_W-1:0]  emit_last;
    logic [QCNT_W-1:0]  pending;

    assign pending = queue_count + QCNT_W'(s1_valid_reg);
    assign full    = clear_reg || (pending >= QCNT_W'(QUEUE_DEPTH));
    assign accept  = push && !full;

    assign idx_ext      = 32'(pixel_index);
    assign ctr_ext      = 32'(counter_reg);
    assign rd_addr      = ctr_ext[AW-1:0];
    assign ctr_in_range = ctr_ext < 32'(PIXEL_DEPTH);

    always_comb
    begin
        if (clear_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = clear_addr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = accept && (kind == KIND_WRITE) && (idx_ext < 32'(PIXEL_DEPTH));
            wr_addr = idx_ext[AW-1:0];
            wr_data = pixel_color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= store_mem[rd_addr];
    end

    assign in_active = counter_reg < COUNT_W'(cfg.active_pixels);
    assign gap_diff  = counter_reg - COUNT_W'(cfg.active_pixels);
    assign gap_m1    = (cfg.reset_frames == '0) ? '0 : cfg.reset_frames - 1'b1;
    assign gap_end   = gap_diff >= COUNT_W'(gap_m1);

    always_comb
    begin
        counter_next = counter_reg;
        emit         = 1'b0;
        emit_gap     = 1'b0;
        emit_first   = SLOT_FIRST;
        emit_last    = SLOT_LAST;
        if (accept && (kind == KIND_EVENT))
        begin
            if (in_active)
            begin
                emit       = half_flag || done_flag;
                emit_first = half_flag ? SLOT_FIRST : SLOT_MID;
                emit_last  = done_flag ? SLOT_LAST : SLOT_HALF_END;
                if (done_flag)
                begin
                    counter_next = counter_reg + 1'b1;
                end
            end
            else if (done_flag)
            begin
                emit     = 1'b1;
                emit_gap = 1'b1;
                counter_next = gap_end ? '0 : counter_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
            counter_reg    <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (clear_reg)
            begin
                clear_addr_reg <= clear_addr_reg + 1'b1;
                if (clear_addr_reg == AW'(PIXEL_DEPTH - 1))
                begin
                    clear_reg <= 1'b0;
                end
            end
            counter_reg  <= counter_next;
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_gap_reg      <= emit_gap;
        s1_in_range_reg <= ctr_in_range;
        s1_first_reg    <= emit_first;
        s1_last_reg     <= emit_last;
    end

    always_comb
    begin
        cmd_req.valid          = s1_valid_reg;
        cmd_req.cmd.gap        = s1_gap_reg;
        cmd_req.cmd.color      = (s1_in_range_reg && !s1_gap_reg) ? rd_data_reg : '0;
        cmd_req.cmd.first_slot = s1_first_reg;
        cmd_req.cmd.last_slot  = s1_last_reg;
    end

endmodule

[sv/wdbr_cmd_fifo.sv]
// Short request queue between the front end and the duty sequencer.
module wdbr_cmd_fifo
    import wdbr_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  cmd_req_t      cmd_req,
    input  logic          pop,
    output queue_status_t status
);

    cmd_t              entry_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    always_comb
    begin
        count_next = count_reg;
        if (cmd_req.valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!cmd_req.valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_req.valid)
        begin
            entry_mem[wr_ptr_reg] <= cmd_req.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (cmd_req.valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign status.empty = (count_reg == '0);
    assign status.count = count_reg;
    assign status.head  = entry_mem[rd_ptr_reg];

endmodule

[sv/wdbr_back.sv]
// Back end: steps through the slots of each request and emits one duty a cycle while the output is popped.
module wdbr_back
    import wdbr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  queue_status_t      qstat,
    output logic               queue_pop,
    output logic               empty,
    input  logic               pop,
    output logic [SLOT_W-1:0]  slot,
    output logic [DUTY_W-1:0]  duty,
    output logic               last
);

    logic              started_reg;
    logic [SLOT_W-1:0] cur_slot_reg;
    logic              out_valid_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic [DUTY_W-1:0] out_duty_reg;
    logic              out_last_reg;

    logic              advance;
    logic              work;
    logic [SLOT_W-1:0] slot_now;
    logic [SLOT_W-1:0] bit_pos;
    logic              color_bit;
    logic              is_last;
    logic [DUTY_W-1:0] duty_now;

    assign advance   = !out_valid_reg || pop;
    assign work      = advance && !qstat.empty;
    assign slot_now  = started_reg ? cur_slot_reg : qstat.head.first_slot;
    assign bit_pos   = SLOT_LAST - slot_now;
    assign color_bit = qstat.head.color[bit_pos];
    assign is_last   = (slot_now == qstat.head.last_slot);
    assign duty_now  = qstat.head.gap ? '0 : (color_bit ? cfg.duty_one : cfg.duty_zero);
    assign queue_pop = work && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            cur_slot_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= work;
            end
            if (work)
            begin
                started_reg  <= !is_last;
                cur_slot_reg <= slot_now + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (work)
        begin
            out_slot_reg <= slot_now;
            out_duty_reg <= duty_now;
            out_last_reg <= is_last;
        end
    end

    assign empty = !out_valid_reg;
    assign slot  = out_slot_reg;
    assign duty  = out_duty_reg;
    assign last  = out_last_reg;

endmodule

[sv/ws2812_duty_buffer_refill.sv]
// Top level of the addressable LED duty-buffer refill block.
// Pixel writes and refill events enter through a queue-style port and are taken one a cycle
// while the four-entry request queue has room; a store write gives no result, a half or done
// event gives 12 results and an event with both flags or a reset frame gives 24. Results leave
// at one per cycle from the duty sequencer's output register while the receiver pops them; the
// first result of an event passes through the front end's stage register, the request queue and
// that output register. After reset the pixel store is zeroed by a clearing pass over all
// PIXEL_DEPTH entries, during which full stays high; configuration writes are taken at any time.
module ws2812_duty_buffer_refill
    import wdbr_pkg::*;
#(
    parameter int PIXEL_DEPTH = 1024
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic                   kind,
    input  logic [INDEX_W-1:0]     pixel_index,
    input  logic [COLOR_W-1:0]     pixel_color,
    input  logic                   half_flag,
    input  logic                   done_flag,
    output logic                   empty,
    input  logic                   pop,
    output logic [SLOT_W-1:0]      slot,
    output logic [DUTY_W-1:0]      duty,
    output logic                   last
);

    cfg_t          cfg_reg;
    cmd_req_t      cmd_req;
    queue_status_t qstat;
    logic          queue_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.active_pixels <= 11'd1024;
            cfg_reg.duty_one      <= 8'd65;
            cfg_reg.duty_zero     <= 8'd32;
            cfg_reg.reset_frames  <= 8'd9;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACTIVE_PIXELS: cfg_reg.active_pixels <= cfg_data[ACTIVE_W-1:0];
                REG_DUTY_ONE:      cfg_reg.duty_one      <= cfg_data[DUTY_W-1:0];
                REG_DUTY_ZERO:     cfg_reg.duty_zero     <= cfg_data[DUTY_W-1:0];
                REG_RESET_FRAMES:  cfg_reg.reset_frames  <= cfg_data[FRAMES_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    wdbr_front #(
        .PIXEL_DEPTH (PIXEL_DEPTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pixel_index (pixel_index),
        .pixel_color (pixel_color),
        .half_flag   (half_flag),
        .done_flag   (done_flag),
        .queue_count (qstat.count),
        .cmd_req     (cmd_req)
    );

    wdbr_cmd_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd_req (cmd_req),
        .pop     (queue_pop),
        .status  (qstat)
    );

    wdbr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .qstat     (qstat),
        .queue_pop (queue_pop),
        .empty     (empty),
        .pop       (pop),
        .slot      (slot),
        .duty      (duty),
        .last      (last)
    );

`ifndef ASSERT_OFF
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd_req.valid && (qstat.count == QCNT_W'(QUEUE_DEPTH)) && !queue_pop))
        else $error("request queue written while full");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (slot <= SLOT_LAST))
        else $error("result slot beyond the duty buffer");

    a_request_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && !last) |=> !empty)
        else $error("gap inside the results of one request");
`endif

endmodule

[tb/ws2812_duty_buffer_refill_test.sv]
// Self-checking testbench for the LED duty-buffer refill block.
`timescale 1ns / 100ps

module ws2812_duty_buffer_refill_test;
    import wdbr_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int COUNT_MASK = (1 << COUNT_W) - 1;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [DUTY_W-1:0] duty;
        logic              last;
    } duty_rec_t;

    typedef struct {
        logic               kind;
        logic [INDEX_W-1:0] index;
        logic [COLOR_W-1:0] color;
        logic               half;
        logic               done;
    } led_req_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic push = 1'b0;
    logic full;
    logic kind = KIND_WRITE;
    logic [INDEX_W-1:0] pixel_index = '0;
    logic [COLOR_W-1:0] pixel_color = '0;
    logic half_flag = 1'b0;
    logic done_flag = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [SLOT_W-1:0] slot;
    logic [DUTY_W-1:0] duty;
    logic last;

    led_req_t item_fifo[$];
    duty_rec_t duty_expect_q[$];
    logic [COLOR_W-1:0] pixel_mem [0:STORE_DEPTH-1];
    int frame_pos = 0;
    int cfg_active = 1024;
    logic [DUTY_W-1:0] cfg_one = 8'd65;
    logic [DUTY_W-1:0] cfg_zero = 8'd32;
    int cfg_frames = 9;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_req = 1'b0;
    logic stall_hold = 1'b0;
    int err_count = 0;

    ws2812_duty_buffer_refill dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pixel_index (pixel_index),
        .pixel_color (pixel_color),
        .half_flag   (half_flag),
        .done_flag   (done_flag),
        .empty       (empty),
        .pop         (pop),
        .slot        (slot),
        .duty        (duty),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic predict_duties(input logic k, input logic [INDEX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] col, input logic h,
                                  input logic d);
        duty_rec_t batch[$];
        duty_rec_t rec;
        logic [COLOR_W-1:0] pix;
        int gap;
        int i;
        if (k == KIND_WRITE)
        begin
            pixel_mem[idx] = col;
            return;
        end
        rec.last = 1'b0;
        if (frame_pos < cfg_active)
        begin
            pix = '0;
            if (frame_pos < STORE_DEPTH)
                pix = pixel_mem[frame_pos];
            for (i = 0; i < BITS_PER_PIXEL; i++)
            begin
                if ((i < HALF_BITS) ? h : d)
                begin
                    rec.slot = SLOT_W'(i);
                    rec.duty = pix[BITS_PER_PIXEL-1-i] ? cfg_one : cfg_zero;
                    batch.push_back(rec);
                end
            end
            if (d)
                frame_pos = (frame_pos + 1) & COUNT_MASK;
        end
        else if (d)
        begin
            gap = (cfg_frames == 0) ? 1 : cfg_frames;
            rec.duty = '0;
            for (i = 0; i < BITS_PER_PIXEL; i++)
            begin
                rec.slot = SLOT_W'(i);
                batch.push_back(rec);
            end
            if (frame_pos - cfg_active >= gap - 1)
                frame_pos = 0;
            else
                frame_pos = (frame_pos + 1) & COUNT_MASK;
        end
        if (batch.size() > 0)
        begin
            batch[batch.size()-1].last = 1'b1;
            foreach (batch[j])
                duty_expect_q.push_back(batch[j]);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : sender
        led_req_t nxt;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
                predict_duties(kind, pixel_index, pixel_color, half_flag, done_flag);
            if (!push || !full)
            begin
                if (item_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = item_fifo.pop_front();
                    push <= 1'b1;
                    kind <= nxt.kind;
                    pixel_index <= nxt.index;
                    pixel_color <= nxt.color;
                    half_flag <= nxt.half;
                    done_flag <= nxt.done;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : receiver
        duty_rec_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (duty_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result, slot %0d duty %0d last %0b",
                             $time, slot, duty, last);
                    err_count++;
                end
                else
                begin
                    want = duty_expect_q.pop_front();
                    if (slot !== want.slot)
                    begin
                        $display("%0t: slot expected %0d, actual %0d", $time, want.slot, slot);
                        err_count++;
                    end
                    if (duty !== want.duty)
                    begin
                        $display("%0t: duty expected %0d, actual %0d", $time, want.duty, duty);
                        err_count++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last expected %0b, actual %0b", $time, want.last, last);
                        err_count++;
                    end
                end
            end
            pop <= !stall_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin : receiver_hold
        wait (hold_req);
        @(posedge clk);
        stall_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold <= 1'b0;
    end

    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    function automatic void add_item(input logic k, input logic [INDEX_W-1:0] idx,
                                     input logic [COLOR_W-1:0] col, input logic h,
                                     input logic d);
        led_req_t it;
        it.kind = k;
        it.index = idx;
        it.color = col;
        it.half = h;
        it.done = d;
        item_fifo.push_back(it);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] ridx, input int val);
        logic [31:0] mask;
        logic [31:0] wdata;
        mask = (ridx == REG_ACTIVE_PIXELS) ? 32'h7FF : 32'hFF;
        wdata = ($urandom & ~mask) | (32'(val) & mask);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ridx;
        cfg_data <= wdata;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (ridx)
            REG_ACTIVE_PIXELS: cfg_active = int'(wdata[ACTIVE_W-1:0]);
            REG_DUTY_ONE:      cfg_one = wdata[DUTY_W-1:0];
            REG_DUTY_ZERO:     cfg_zero = wdata[DUTY_W-1:0];
            REG_RESET_FRAMES:  cfg_frames = int'(wdata[FRAMES_W-1:0]);
            default:           ;
        endcase
    endtask

    task automatic set_regs(input int act, input int one, input int zero, input int frames);
        write_reg(REG_ACTIVE_PIXELS, act);
        write_reg(REG_DUTY_ONE, one);
        write_reg(REG_DUTY_ZERO, zero);
        write_reg(REG_RESET_FRAMES, frames);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (item_fifo.size() != 0 || push || duty_expect_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic queue_random(input int n);
        int made;
        int r;
        logic [INDEX_W-1:0] idx;
        made = 0;
        while (made < n)
        begin
            r = $urandom_range(99);
            idx = $urandom_range(1) ? INDEX_W'($urandom_range(7)) : INDEX_W'($urandom);
            if (r < 25)
            begin
                add_item(KIND_WRITE, idx, COLOR_W'($urandom), 1'($urandom), 1'($urandom));
                made++;
            end
            else if (r < 80)
            begin
                add_item(KIND_EVENT, idx, COLOR_W'($urandom), 1'b1, 1'b0);
                add_item(KIND_EVENT, INDEX_W'($urandom), COLOR_W'($urandom), 1'b0, 1'b1);
                made += 2;
            end
            else
            begin
                add_item(KIND_EVENT, idx, COLOR_W'($urandom), 1'($urandom), 1'($urandom));
                made++;
            end
        end
    endtask

    task automatic run_phase(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        queue_random(n);
        wait_idle();
    endtask

    initial
    begin
        int i;
        for (i = 0; i < STORE_DEPTH; i++)
            pixel_mem[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset values of the registers and the cleared store.
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b0);
        add_item(KIND_WRITE, 10'd0, 24'hFFFFFF, 1'b1, 1'b1);
        add_item(KIND_EVENT, 10'h3FF, 24'hFFFFFF, 1'b0, 1'b1);
        add_item(KIND_WRITE, 10'h3FF, 24'h800001, 1'b0, 1'b0);
        add_item(KIND_EVENT, 10'd5, 24'h123456, 1'b0, 1'b0);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b1);
        wait_idle();

        // Walk through the active pixels into the latch gap.
        set_regs(3, 255, 0, 2);
        add_item(KIND_WRITE, 10'd2, 24'hA5C35A, 1'b0, 1'b0);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b1);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b0);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b0, 1'b1);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b1);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b0);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b0, 1'b1);
        wait_idle();

        // A gap length of zero behaves as one frame.
        set_regs(1, 200, 7, 0);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b0, 1'b1);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b1);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b0, 1'b1);
        wait_idle();

        // With no active pixels every done request is a latch frame.
        set_regs(0, 1, 2, 1);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b1);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b1, 1'b0);
        add_item(KIND_EVENT, 10'd0, 24'd0, 1'b0, 1'b1);
        wait_idle();

        set_regs(1, 8'h5A, 8'hA5, 1);
        run_phase(60, 0, 0);
        set_regs(7, 0, 255, 255);
        run_phase(50, 84, 0);
        set_regs(4, 255, 0, 3);
        run_phase(60, 0, 84);
        set_regs(1024, $urandom_range(255), $urandom_range(255), 2);
        run_phase(50, 34, 34);

        // The receiver holds off while requests keep coming, so the input backs up.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req = 1'b1;
        for (i = 0; i < 30; i++)
            add_item(KIND_EVENT, INDEX_W'($urandom), COLOR_W'($urandom), 1'b1, 1'b1);
        wait_idle();

        if (err_count == 0 && duty_expect_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
